// ----- hw/rtl/fspa_pkg.sv -----
// Shared types, constants and codes of the fragmented slot pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package fspa_pkg;

  localparam int unsigned MAX_FRAGMENTS = 64;
  localparam int unsigned MAX_SLOTS     = 256;

  localparam int unsigned SLOT_CNT_W   = 9;
  localparam int unsigned FRAG_ID_W    = 6;
  localparam int unsigned SLOT_W       = 8;
  localparam int unsigned LIVE_TOTAL_W = 15;
  localparam int unsigned FSLOTS_W     = 9;
  localparam int unsigned INIT_W       = 7;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 9;

  localparam logic [FSLOTS_W-1:0] FSLOTS_RST = 9'd256;
  localparam logic [INIT_W-1:0]   INIT_RST   = 7'd8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAGMENT_SLOTS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_FRAGMENTS = 2'd1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_RANGE     = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic                 op;
    logic [FRAG_ID_W-1:0] frag_sel;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [FRAG_ID_W-1:0]    fragment;
    logic [SLOT_W-1:0]       slot;
    logic [LIVE_TOTAL_W-1:0] live_total;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_word_t;

  // Per-fragment counters held in the RAM.
  typedef struct packed {
    logic [SLOT_CNT_W-1:0] live;
    logic [SLOT_CNT_W-1:0] next_slot;
  } entry_t;

  typedef struct packed {
    logic in_ready;
    logic cfg_ready;
    logic exec;
    logic search;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_search;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fspa_stream_if.sv -----
// Valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps
`default_nettype none

interface fspa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fspa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fspa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fspa_ctrl.sv -----
// Sequencer: accept, read-modify-write, optional room search.
`timescale 1ns / 1ps
`default_nettype none

module fspa_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         cfg_valid_i,
  input  wire fspa_pkg::sts_t sts_i,
  output fspa_pkg::cmd_t    cmd_o
);

  fspa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fspa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fspa_pkg::ST_IDLE: begin
        if (in_valid_i && !cfg_valid_i) state_d = fspa_pkg::ST_EXEC;
      end
      fspa_pkg::ST_EXEC: begin
        if (sts_i.out_free) begin
          state_d = sts_i.need_search ? fspa_pkg::ST_SEARCH : fspa_pkg::ST_IDLE;
        end
      end
      fspa_pkg::ST_SEARCH: begin
        state_d = fspa_pkg::ST_IDLE;
      end
      default: begin
        state_d = fspa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      fspa_pkg::ST_IDLE: begin
        // configuration wins a tie with an item
        cmd_o.cfg_ready = 1'b1;
        cmd_o.in_ready  = !cfg_valid_i;
      end
      fspa_pkg::ST_EXEC: begin
        cmd_o.exec = sts_i.out_free;
      end
      fspa_pkg::ST_SEARCH: begin
        cmd_o.search = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fspa_datapath.sv -----
// Pool state, counter RAM, room search and result register.
`timescale 1ns / 1ps
`default_nettype none

module fspa_datapath #(
  parameter int unsigned MaxFragments = fspa_pkg::MAX_FRAGMENTS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fspa_pkg::cmd_t      cmd_i,
  output fspa_pkg::sts_t           sts_o,
  input  wire logic                in_valid_i,
  input  wire fspa_pkg::in_word_t  in_data_i,
  input  wire logic                cfg_valid_i,
  input  wire fspa_pkg::cfg_word_t cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output fspa_pkg::out_word_t      out_data_o
);

  localparam int unsigned IdxW  = (MaxFragments > 1) ? $clog2(MaxFragments) : 1;
  localparam int unsigned ActW  = $clog2(MaxFragments + 1);
  localparam int unsigned CmpW  = ActW + fspa_pkg::FRAG_ID_W;
  localparam int unsigned LiveW = $clog2(MaxFragments * fspa_pkg::MAX_SLOTS + 1);
  localparam int unsigned SW    = fspa_pkg::SLOT_CNT_W;
  localparam int unsigned EntW  = $bits(fspa_pkg::entry_t);

  function automatic logic [ActW-1:0] eff_init(input logic [fspa_pkg::INIT_W-1:0] v);
    if (v == '0) begin
      eff_init = ActW'(1);
    end else if (32'(v) > MaxFragments) begin
      eff_init = ActW'(MaxFragments);
    end else begin
      eff_init = ActW'(v);
    end
  endfunction

  // configuration and pool state
  logic [fspa_pkg::FSLOTS_W-1:0] fs_q;
  logic [fspa_pkg::INIT_W-1:0]   init_q;
  logic [ActW-1:0]               act_q;
  logic [IdxW-1:0]               cur_q;
  logic                          cur_vld_q;
  logic [LiveW-1:0]              live_q;
  logic [MaxFragments-1:0]       vld_q;
  logic [MaxFragments-1:0]       room_q;
  logic                          out_vld_q;
  fspa_pkg::out_word_t           out_q;

  // item held during its update
  logic                          op_q;
  logic [fspa_pkg::FRAG_ID_W-1:0] fid_q;
  logic [IdxW-1:0]               addr_q;

  logic                in_acc, cfg_acc, reinit;
  logic [fspa_pkg::INIT_W-1:0] init_new;
  logic [IdxW-1:0]     rd_addr;
  logic [EntW-1:0]     rdata;
  fspa_pkg::entry_t    entry, wentry;
  logic [SW-1:0]       cap, ns_inc, lv_dec;
  logic                exhausted, full, fid_ok, wr_en, need_search;
  fspa_pkg::out_word_t res;
  logic [MaxFragments-1:0] cand;
  logic                hit;
  logic [IdxW-1:0]     hit_idx;

  assign in_acc  = in_valid_i && cmd_i.in_ready;
  assign cfg_acc = cfg_valid_i && cmd_i.cfg_ready;
  assign reinit  = cfg_acc && (cfg_data_i.index == fspa_pkg::REG_FRAGMENT_SLOTS ||
                               cfg_data_i.index == fspa_pkg::REG_INITIAL_FRAGMENTS);
  assign init_new = (cfg_data_i.index == fspa_pkg::REG_INITIAL_FRAGMENTS) ?
                    cfg_data_i.wdata[fspa_pkg::INIT_W-1:0] : init_q;

  // allocate goes to the current fragment, or to a new one if none is current
  assign rd_addr = (in_data_i.op == fspa_pkg::OP_RELEASE) ? IdxW'(in_data_i.frag_sel) :
                   (cur_vld_q ? cur_q : IdxW'(act_q));

  fspa_ram #(
    .Width (EntW),
    .Depth (MaxFragments)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && wr_en),
    .waddr_i (addr_q),
    .wdata_i (wentry),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    if (fs_q == '0) begin
      cap = SW'(1);
    end else if (32'(fs_q) > fspa_pkg::MAX_SLOTS) begin
      cap = SW'(fspa_pkg::MAX_SLOTS);
    end else begin
      cap = SW'(fs_q);
    end
  end

  // never-written entries read as zero
  assign entry     = vld_q[addr_q] ? fspa_pkg::entry_t'(rdata) : '0;
  assign ns_inc    = entry.next_slot + SW'(1);
  assign lv_dec    = entry.live - SW'(1);
  assign full      = ns_inc >= cap;
  assign exhausted = !cur_vld_q && (act_q == ActW'(MaxFragments));
  assign fid_ok    = CmpW'(fid_q) < CmpW'(act_q);

  always_comb begin
    wr_en       = 1'b0;
    need_search = 1'b0;
    wentry      = entry;
    res         = '0;
    if (op_q == fspa_pkg::OP_ALLOC) begin
      if (exhausted) begin
        res.status = fspa_pkg::STATUS_EXHAUSTED;
      end else begin
        wr_en            = 1'b1;
        wentry.live      = entry.live + SW'(1);
        wentry.next_slot = ns_inc;
        need_search      = full;
        res.status       = fspa_pkg::STATUS_OK;
        res.fragment     = fspa_pkg::FRAG_ID_W'(addr_q);
        res.slot         = entry.next_slot[fspa_pkg::SLOT_W-1:0];
      end
    end else begin
      if (!fid_ok) begin
        res.status = fspa_pkg::STATUS_RANGE;
      end else if (entry.live == '0) begin
        res.status = fspa_pkg::STATUS_EMPTY;
      end else begin
        wr_en            = 1'b1;
        wentry.live      = lv_dec;
        wentry.next_slot = (lv_dec == '0) ? '0 : entry.next_slot;
        res.status       = fspa_pkg::STATUS_OK;
      end
    end
    res.live_total = fspa_pkg::LIVE_TOTAL_W'(live_q);
    if (wr_en) begin
      res.live_total = (op_q == fspa_pkg::OP_ALLOC) ?
                       fspa_pkg::LIVE_TOTAL_W'(live_q + LiveW'(1)) :
                       fspa_pkg::LIVE_TOTAL_W'(live_q - LiveW'(1));
    end
  end

  // lowest active fragment with room
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MaxFragments; i++) begin
      cand[i] = room_q[i] && (ActW'(i) < act_q);
    end
    for (int i = MaxFragments - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  assign sts_o.out_free    = !out_vld_q || out_ready_i;
  assign sts_o.need_search = need_search;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= in_data_i.op;
      fid_q  <= in_data_i.frag_sel;
      addr_q <= rd_addr;
    end
    if (cmd_i.exec) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q      <= fspa_pkg::FSLOTS_RST;
      init_q    <= fspa_pkg::INIT_RST;
      act_q     <= eff_init(fspa_pkg::INIT_RST);
      cur_q     <= '0;
      cur_vld_q <= 1'b1;
      live_q    <= '0;
      vld_q     <= '0;
      room_q    <= '1;
      out_vld_q <= 1'b0;
    end else begin
      if (reinit) begin
        if (cfg_data_i.index == fspa_pkg::REG_FRAGMENT_SLOTS) begin
          fs_q <= cfg_data_i.wdata;
        end
        init_q    <= init_new;
        act_q     <= eff_init(init_new);
        cur_q     <= '0;
        cur_vld_q <= 1'b1;
        live_q    <= '0;
        vld_q     <= '0;
        room_q    <= '1;
      end
      if (cmd_i.exec && wr_en) begin
        vld_q[addr_q] <= 1'b1;
        if (op_q == fspa_pkg::OP_ALLOC) begin
          if (!cur_vld_q) act_q <= act_q + ActW'(1);
          cur_q          <= addr_q;
          cur_vld_q      <= !full;
          room_q[addr_q] <= !full;
          live_q         <= live_q + LiveW'(1);
        end else begin
          if (lv_dec == '0) begin
            room_q[addr_q] <= 1'b1;
            if (cur_q == addr_q) cur_vld_q <= 1'b1;
          end
          live_q <= live_q - LiveW'(1);
        end
      end
      if (cmd_i.search && hit) begin
        cur_q     <= hit_idx;
        cur_vld_q <= 1'b1;
      end
      if (cmd_i.exec) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fragmented_slot_pool_allocator_top.sv -----
// Top level of the fragmented slot pool allocator.
`timescale 1ns / 1ps
`default_nettype none

// Slab-style pool allocator with a bump index per fragment. Each input word is an
// allocate (op 0) or a release (op 1, naming a fragment) and yields exactly one
// result word: status, fragment, slot and the live total after the operation.
// Words are handled one at a time. The accept cycle ends with the fragment's
// counters read from the counter RAM; the update state then writes them back and
// loads the result register, and the next word can be taken once the sequencer
// is back in idle. An allocate that fills its fragment also passes through a
// search state, in which a priority encoder over the per-fragment room bits
// picks the lowest active fragment with space. The result register lets the
// next word in while a result still waits; an item stalls in its update cycle
// only if the previous result has not been taken. Configuration writes
// (fragment_slots at index 0, initial_fragments at index 1) are taken only while
// no item is in flight and reset the whole pool at once; per-fragment valid bits
// stand in for clearing the RAM, so there is no clearing pass after reset.
// Out-of-range values are saturated; initial_fragments keeps only its low 7 bits.

module fragmented_slot_pool_allocator_top #(
  parameter int unsigned MaxFragments = fspa_pkg::MAX_FRAGMENTS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  fspa_stream_if.sink   in_i,
  fspa_stream_if.source out_o,
  fspa_stream_if.sink   cfg_i
);

  fspa_pkg::cmd_t cmd;
  fspa_pkg::sts_t sts;

  fspa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .cfg_valid_i (cfg_i.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fspa_datapath #(
    .MaxFragments (MaxFragments)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  // ready words come straight from the sequencer
  assign in_i.ready  = cmd.in_ready;
  assign cfg_i.ready = cmd.cfg_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/fspa_checker.sv -----
// Port-level checks of the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fspa_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire fspa_pkg::out_word_t out_data_i
);

  // one word at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i |-> !(in_valid_i && in_ready_i))
    else $error("config write and input word in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != fspa_pkg::STATUS_OK) |->
      out_data_i.fragment == '0 && out_data_i.slot == '0)
    else $error("failed operation reports a fragment or slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result word changed");

endmodule

bind fragmented_slot_pool_allocator_top fspa_checker u_fspa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
